// ===== design/swdc_pkg.sv =====
// shared types, sizes and codes for the sequence window dedup counter
`default_nettype none

package swdc_pkg;

  localparam int unsigned MaxSequence = 65535;
  localparam int unsigned CntW        = 32;
  localparam int unsigned OutW        = 32;
  localparam int unsigned TimeW       = 64;
  localparam int unsigned SizeW       = 32;

  // seen bitmap is kept as rows of WordW bits
  localparam int unsigned WordW = 32;
  localparam int unsigned BitW  = $clog2(WordW);
  localparam int unsigned SeqW  = $clog2(MaxSequence + 1);
  localparam int unsigned RowW  = (SeqW > BitW) ? (SeqW - BitW) : 1;
  localparam int unsigned IdxW  = RowW + BitW;
  localparam int unsigned Rows  = 2 ** RowW;

  localparam int unsigned InDataW  = 168;
  localparam int unsigned OutDataW = 136;

  typedef enum logic [1:0] {
    PH_PROBE   = 2'd0,
    PH_BARRIER = 2'd1,
    PH_WARMUP  = 2'd2,
    PH_MEASURE = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    OUT_INVALID      = 4'd0,
    OUT_PROBE        = 4'd1,
    OUT_BARRIER      = 4'd2,
    OUT_WARMUP       = 4'd3,
    OUT_WARMUP_LATE  = 4'd4,
    OUT_EARLY        = 4'd5,
    OUT_CUTOFF       = 4'd6,
    OUT_WIN_UNIQUE   = 4'd7,
    OUT_DRAIN_UNIQUE = 4'd8,
    OUT_WIN_DUP      = 4'd9,
    OUT_DRAIN_DUP    = 4'd10
  } outcome_e;

  typedef enum logic [3:0] {
    CNT_INVALID      = 4'd0,
    CNT_WARMUP       = 4'd1,
    CNT_WARMUP_LATE  = 4'd2,
    CNT_EARLY        = 4'd3,
    CNT_CUTOFF       = 4'd4,
    CNT_WIN_UNIQUE   = 4'd5,
    CNT_DRAIN_UNIQUE = 4'd6,
    CNT_WIN_DUP      = 4'd7,
    CNT_DRAIN_DUP    = 4'd8,
    CNT_FORMAL       = 4'd9,
    CNT_SHM          = 4'd10
  } cnt_e;

  localparam int unsigned NumCnt = 11;

  typedef enum logic [2:0] {
    CFG_WINDOW_START  = 3'd0,
    CFG_WINDOW_END    = 3'd1,
    CFG_DRAIN_CUTOFF  = 3'd2,
    CFG_EXPECTED_SIZE = 3'd3,
    CFG_LOAN_MODE     = 3'd4
  } cfg_e;

  // bit positions inside the output tdata, shared with the checker
  localparam int unsigned OdClassLo   = 0;
  localparam int unsigned OdWarmupLo  = 32;
  localparam int unsigned OdProbeBit  = 128;
  localparam int unsigned OdBarrierBit = 129;

endpackage

`default_nettype wire

// ===== design/sequence_window_dedup_counter.sv =====
// top level: classifies message descriptors against the window and a seen bitmap
//
// One descriptor is accepted per clock unless the output stalls; its result is
// registered in the first stage, then in the output register. The block sustains
// one transaction per cycle because the only state touched by consecutive
// descriptors is the seen bitmap (one row read, one row written back, with the
// last written row forwarded) and the class counters, which saturate. After reset
// the bitmap is cleared one 32-bit row per cycle, 2048 rows by default, and no
// descriptor is accepted before that; configuration writes are taken at any time.
`default_nettype none

module sequence_window_dedup_counter import swdc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_idx_i,
  input  wire logic [63:0]         cfg_wdata_i,
  // descriptor stream
  input  wire logic                s_axis_tvalid_i,
  output      logic                s_axis_tready_o,
  // completion_time[63:0], sequence_req[127:64], payload_ok[128], path_ok[129],
  // msg_size[161:130], zero fill above
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // phase[1:0]
  input  wire logic [1:0]          s_axis_tuser_i,
  // result stream
  output      logic                m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // class_count[31:0], warmup_total[63:32], formal_total[95:64], shm_total[127:96],
  // probe_seen[128], barrier_seen[129], zero fill above
  output      logic [OutDataW-1:0] m_axis_tdata_o,
  // outcome[3:0]
  output      logic [3:0]          m_axis_tuser_o
);

  // configuration registers
  logic [TimeW-1:0] win_start_q, win_end_q, cutoff_q;
  logic [SizeW-1:0] exp_size_q;
  logic             loan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= '0;
      win_end_q   <= '0;
      cutoff_q    <= '1;
      exp_size_q  <= '0;
      loan_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_WINDOW_START:  win_start_q <= cfg_wdata_i;
        CFG_WINDOW_END:    win_end_q   <= cfg_wdata_i;
        CFG_DRAIN_CUTOFF:  cutoff_q    <= cfg_wdata_i;
        CFG_EXPECTED_SIZE: exp_size_q  <= cfg_wdata_i[SizeW-1:0];
        CFG_LOAN_MODE:     loan_q      <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [TimeW-1:0] in_time;
  logic [63:0]      in_seq;
  logic             in_pay, in_path;
  logic [SizeW-1:0] in_size;
  phase_e           in_phase;

  assign in_time  = s_axis_tdata_i[63:0];
  assign in_seq   = s_axis_tdata_i[127:64];
  assign in_pay   = s_axis_tdata_i[128];
  assign in_path  = s_axis_tdata_i[129];
  assign in_size  = s_axis_tdata_i[161:130];
  assign in_phase = phase_e'(s_axis_tuser_i);

  // pipeline control
  logic clr_q;
  logic [RowW-1:0] clr_row_q;
  logic s1_vld_q;
  logic out_vld_q;
  logic adv, s1_fire, accept;

  assign adv             = !out_vld_q || m_axis_tready_i;
  assign s1_fire         = s1_vld_q && adv;
  assign s_axis_tready_o = !clr_q && (!s1_vld_q || adv);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // first stage: everything except the bitmap lookup
  outcome_e s1_out_d;
  logic     s1_meas_d, s1_chk_d, s1_win_d;

  always_comb begin
    s1_out_d  = OUT_INVALID;
    s1_meas_d = 1'b0;
    s1_chk_d  = 1'b0;
    s1_win_d  = in_time < win_end_q;
    if (in_size == exp_size_q && in_pay && in_path) begin
      case (in_phase)
        PH_PROBE:   s1_out_d = OUT_PROBE;
        PH_BARRIER: s1_out_d = OUT_BARRIER;
        PH_WARMUP: begin
          if (win_start_q != '0 && in_time >= win_start_q) s1_out_d = OUT_WARMUP_LATE;
          else s1_out_d = OUT_WARMUP;
        end
        PH_MEASURE: begin
          s1_meas_d = 1'b1;
          if (in_seq == 64'd0 || in_seq > 64'(MaxSequence)) s1_out_d = OUT_INVALID;
          else if (in_time < win_start_q) s1_out_d = OUT_EARLY;
          else if (in_time >= cutoff_q) s1_out_d = OUT_CUTOFF;
          else begin
            s1_out_d = OUT_WIN_UNIQUE;
            s1_chk_d = 1'b1;
          end
        end
        default: s1_out_d = OUT_INVALID;
      endcase
    end
  end

  outcome_e        s1_out_q;
  logic            s1_meas_q, s1_chk_q, s1_win_q;
  logic [RowW-1:0] s1_row_q;
  logic [BitW-1:0] s1_bit_q;
  logic [IdxW-1:0] in_idx;

  assign in_idx = in_seq[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (accept) begin
      s1_vld_q <= 1'b1;
    end else if (adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_out_q  <= s1_out_d;
      s1_meas_q <= s1_meas_d;
      s1_chk_q  <= s1_chk_d;
      s1_win_q  <= s1_win_d;
      s1_row_q  <= in_idx[IdxW-1:BitW];
      s1_bit_q  <= in_idx[BitW-1:0];
    end
  end

  // seen bitmap memory, one row read per accepted descriptor
  logic [WordW-1:0] seen_mem [Rows];
  logic [WordW-1:0] rd_data_q;
  logic             mem_we;
  logic [RowW-1:0]  mem_waddr;
  logic [WordW-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) seen_mem[mem_waddr] <= mem_wdata;
    if (accept) rd_data_q <= seen_mem[in_idx[IdxW-1:BitW]];
  end

  // last row written, covers a read issued in the same cycle as its write
  logic             fwd_vld_q;
  logic [RowW-1:0]  fwd_row_q;
  logic [WordW-1:0] fwd_data_q;
  logic [WordW-1:0] row_data, row_new;
  logic             seen, upd;

  assign row_data = (fwd_vld_q && fwd_row_q == s1_row_q) ? fwd_data_q : rd_data_q;
  assign seen     = row_data[s1_bit_q];
  assign row_new  = row_data | (WordW'(1) << s1_bit_q);
  assign upd      = s1_fire && s1_chk_q;

  assign mem_we    = clr_q || upd;
  assign mem_waddr = clr_q ? clr_row_q : s1_row_q;
  assign mem_wdata = clr_q ? '0 : row_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_row_q <= '0;
      fwd_vld_q <= 1'b0;
    end else begin
      if (clr_q) begin
        clr_row_q <= clr_row_q + RowW'(1);
        if (clr_row_q == RowW'(Rows - 1)) clr_q <= 1'b0;
      end
      if (upd) fwd_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      fwd_row_q  <= s1_row_q;
      fwd_data_q <= row_new;
    end
  end

  // second stage: final outcome and counter update
  outcome_e          fin_out;
  cnt_e              cls_sel;
  logic              cls_zero;
  logic [NumCnt-1:0] inc;
  logic [CntW-1:0]   cnt_q [NumCnt];
  logic [CntW-1:0]   cnt_d [NumCnt];
  logic              probe_q, barrier_q, probe_d, barrier_d;

  always_comb begin
    fin_out = s1_out_q;
    if (s1_chk_q) begin
      if (seen) fin_out = s1_win_q ? OUT_WIN_DUP : OUT_DRAIN_DUP;
      else      fin_out = s1_win_q ? OUT_WIN_UNIQUE : OUT_DRAIN_UNIQUE;
    end
  end

  always_comb begin
    inc       = '0;
    cls_sel   = CNT_INVALID;
    cls_zero  = 1'b0;
    probe_d   = probe_q;
    barrier_d = barrier_q;
    case (fin_out)
      OUT_INVALID:      cls_sel = CNT_INVALID;
      OUT_PROBE: begin
        cls_zero = 1'b1;
        probe_d  = 1'b1;
      end
      OUT_BARRIER: begin
        cls_zero  = 1'b1;
        barrier_d = 1'b1;
      end
      OUT_WARMUP:       cls_sel = CNT_WARMUP;
      OUT_WARMUP_LATE: begin
        cls_sel         = CNT_WARMUP_LATE;
        inc[CNT_WARMUP] = 1'b1;
      end
      OUT_EARLY:        cls_sel = CNT_EARLY;
      OUT_CUTOFF:       cls_sel = CNT_CUTOFF;
      OUT_WIN_UNIQUE:   cls_sel = CNT_WIN_UNIQUE;
      OUT_DRAIN_UNIQUE: cls_sel = CNT_DRAIN_UNIQUE;
      OUT_WIN_DUP:      cls_sel = CNT_WIN_DUP;
      OUT_DRAIN_DUP:    cls_sel = CNT_DRAIN_DUP;
      default:          cls_zero = 1'b1;
    endcase
    if (!cls_zero) inc[cls_sel] = 1'b1;
    if (s1_meas_q) begin
      inc[CNT_FORMAL] = 1'b1;
      if (loan_q) inc[CNT_SHM] = 1'b1;
    end
    for (int i = 0; i < NumCnt; i++) begin
      cnt_d[i] = (inc[i] && cnt_q[i] != '1) ? cnt_q[i] + CntW'(1) : cnt_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCnt; i++) cnt_q[i] <= '0;
      probe_q   <= 1'b0;
      barrier_q <= 1'b0;
    end else if (s1_fire) begin
      for (int i = 0; i < NumCnt; i++) cnt_q[i] <= cnt_d[i];
      probe_q   <= probe_d;
      barrier_q <= barrier_d;
    end
  end

  // output register
  logic [OutW-1:0] o_cls_q, o_warm_q, o_formal_q, o_shm_q;
  logic            o_probe_q, o_barrier_q;
  outcome_e        o_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      o_out_q     <= fin_out;
      o_cls_q     <= cls_zero ? '0 : OutW'(cnt_d[cls_sel]);
      o_warm_q    <= OutW'(cnt_d[CNT_WARMUP]);
      o_formal_q  <= OutW'(cnt_d[CNT_FORMAL]);
      o_shm_q     <= OutW'(cnt_d[CNT_SHM]);
      o_probe_q   <= probe_d;
      o_barrier_q <= barrier_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = o_out_q;
  assign m_axis_tdata_o  = {6'd0, o_barrier_q, o_probe_q, o_shm_q, o_formal_q,
                            o_warm_q, o_cls_q};

endmodule

`default_nettype wire

// ===== design/swdc_checker.sv =====
// port-level checker for the sequence window dedup counter, bound to the top level
`default_nettype none

module swdc_checker import swdc_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                m_axis_tvalid_o,
  input wire logic                m_axis_tready_i,
  input wire logic [OutDataW-1:0] m_axis_tdata_o,
  input wire logic [3:0]          m_axis_tuser_o
);

  // a stalled result keeps its payload
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // probe results carry a zero count and the sticky probe flag
  a_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == OUT_PROBE |->
      m_axis_tdata_o[OdProbeBit] && m_axis_tdata_o[OdClassLo +: OutW] == '0)
    else $error("probe result malformed");

  // barrier results carry a zero count and the sticky barrier flag
  a_barrier: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == OUT_BARRIER |->
      m_axis_tdata_o[OdBarrierBit] && m_axis_tdata_o[OdClassLo +: OutW] == '0)
    else $error("barrier result malformed");

  // a plain warmup reports the warmup counter as its class count
  a_warmup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == OUT_WARMUP |->
      m_axis_tdata_o[OdClassLo +: OutW] == m_axis_tdata_o[OdWarmupLo +: OutW])
    else $error("warmup count mismatch");

endmodule

bind sequence_window_dedup_counter swdc_checker u_swdc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
